### rtl/core/cbe_pkg.sv
// Shared types, constants and helper functions of the chunked Base64 CRC-32C encoder.
package cbe_pkg;

    localparam logic [7:0]  CHUNK_BYTES     = 8'd180;
    localparam logic [6:0]  MAX_CHUNK_COUNT = 7'd64;
    localparam logic [31:0] CRC_INIT        = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY        = 32'h82f6_3b78;
    localparam logic [6:0]  PAD_CHAR        = 7'h3d;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic        char_valid;
        logic [6:0]  b64_char;
        logic        chunk_end;
        logic [31:0] chunk_crc;
        logic [13:0] chunk_offset;
        logic        file_end;
        logic [31:0] file_crc;
        logic [13:0] file_length;
        logic [6:0]  chunk_count;
        logic        too_long;
    } t_res;

    typedef struct packed {
        logic        has_chars;
        logic [23:0] group;
        logic [1:0]  fill;
        logic        chunk_end;
        logic [31:0] chunk_crc;
        logic [13:0] chunk_offset;
        logic        file_end;
        logic [31:0] file_crc;
        logic [13:0] file_length;
        logic [6:0]  chunk_count;
        logic        too_long;
    } t_job;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int j = 0; j < 8; j++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

    function automatic logic [23:0] group_align(input logic [23:0] v, input logic [1:0] fill);
        logic [23:0] r;
        case (fill)
            2'd3:    r = v;
            2'd2:    r = {v[15:0], 8'h0};
            default: r = {v[7:0], 16'h0};
        endcase
        return r;
    endfunction

    function automatic logic [6:0] b64_symbol(input logic [5:0] s);
        logic [6:0] r;
        if (s < 6'd26) begin
            r = 7'h41 + {1'b0, s};
        end else if (s < 6'd52) begin
            r = 7'h61 + {1'b0, s - 6'd26};
        end else if (s < 6'd62) begin
            r = 7'h30 + {1'b0, s - 6'd52};
        end else if (s == 6'd62) begin
            r = 7'h2b;
        end else begin
            r = 7'h2f;
        end
        return r;
    endfunction

endpackage

### rtl/core/chunked_base64_crc32c_encoder.sv
// Top level of the chunked Base64 encoder with chunk and file CRC-32C.
//
// Input channel: a beat is taken when push is high and full is low. A beat is
// either one file byte or the end-of-file marker. Result channel: while empty is
// low the oldest result is on o_result, and it leaves when pop is high.
// The front end takes one beat per cycle while full is low and updates both
// CRCs in that cycle. Every third byte, the end of a chunk and the end marker
// each post a job to a four-entry queue. The back end turns a job into four
// character beats, or one status beat, at one beat per cycle while pop allows,
// through a registered output stage. A job's first result passes through the
// job queue and then the output register before it is on o_result. The back end
// emits one character per cycle while popped; full means the job queue is full.
// When pop stays low, the output register holds its beat, the queue fills and
// full is raised; no beat is lost. Bytes beyond the chunk limit are dropped
// and reported with the end marker. After the end marker the block starts a
// new file. Synchronous reset clears all counters, sets both CRCs to all ones
// and empties the queue and the output stage.
module chunked_base64_crc32c_encoder
    import cbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_res o_result
);

    logic job_push;
    t_job job_in;
    logic job_pop;
    logic job_empty;
    t_job job_out;
    logic accept;

    assign accept = push && !full;

    cbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    cbe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (full),
        .o_empty (job_empty),
        .o_job   (job_out)
    );

    cbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (o_result)
    );

endmodule

### rtl/core/cbe_front.sv
// Front end: accepts bytes and end beats, keeps the CRCs and counters, and issues jobs.
module cbe_front
    import cbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_item,
    output logic o_job_push,
    output t_job o_job
);

    logic [15:0] r_group;
    logic [1:0]  r_gfill;
    logic [7:0]  r_cfill;
    logic [31:0] r_chunk_crc;
    logic [31:0] r_file_crc;
    logic [13:0] r_total;
    logic [6:0]  r_chunks;
    logic        r_over;

    logic [15:0] n_group;
    logic [1:0]  n_gfill;
    logic [7:0]  n_cfill;
    logic [31:0] n_chunk_crc;
    logic [31:0] n_file_crc;
    logic [13:0] n_total;
    logic [6:0]  n_chunks;
    logic        n_over;

    logic [31:0] crc_c;
    logic [31:0] crc_f;
    logic [23:0] grp24;
    logic [1:0]  gf_inc;
    logic [7:0]  cf_inc;
    logic [13:0] tot_inc;
    logic        chunk_full;
    logic        drop;
    logic        close_end;

    always_comb begin
        crc_c      = crc32c_byte(r_chunk_crc, i_item.data_byte);
        crc_f      = crc32c_byte(r_file_crc, i_item.data_byte);
        grp24      = {r_group, i_item.data_byte};
        gf_inc     = r_gfill + 2'd1;
        cf_inc     = r_cfill + 8'd1;
        tot_inc    = r_total + 14'd1;
        chunk_full = (cf_inc == CHUNK_BYTES);
        drop       = (r_chunks >= MAX_CHUNK_COUNT);
        close_end  = (r_cfill != 8'd0);

        n_group     = r_group;
        n_gfill     = r_gfill;
        n_cfill     = r_cfill;
        n_chunk_crc = r_chunk_crc;
        n_file_crc  = r_file_crc;
        n_total     = r_total;
        n_chunks    = r_chunks;
        n_over      = r_over;

        o_job_push = 1'b0;
        o_job      = '0;

        if (i_item.req_type == REQ_DATA) begin
            if (drop) begin
                n_over = 1'b1;
            end else begin
                n_chunk_crc = crc_c;
                n_file_crc  = crc_f;
                n_total     = tot_inc;
                n_cfill     = cf_inc;
                n_gfill     = gf_inc;
                n_group     = grp24[15:0];
                if (gf_inc == 2'd3 || chunk_full) begin
                    o_job_push      = i_accept;
                    o_job.has_chars = 1'b1;
                    o_job.group     = group_align(grp24, gf_inc);
                    o_job.fill      = gf_inc;
                    n_group         = '0;
                    n_gfill         = '0;
                end
                if (chunk_full) begin
                    o_job.chunk_end    = 1'b1;
                    o_job.chunk_crc    = crc_c ^ CRC_INIT;
                    o_job.chunk_offset = tot_inc - {6'h0, CHUNK_BYTES};
                    n_chunks           = r_chunks + 7'd1;
                    n_cfill            = '0;
                    n_chunk_crc        = CRC_INIT;
                end
            end
        end else begin
            o_job_push         = i_accept;
            o_job.has_chars    = (r_gfill != 2'd0);
            o_job.group        = group_align({8'h0, r_group}, r_gfill);
            o_job.fill         = r_gfill;
            o_job.chunk_end    = close_end;
            o_job.chunk_crc    = close_end ? (r_chunk_crc ^ CRC_INIT) : 32'h0;
            o_job.chunk_offset = close_end ? (r_total - {6'h0, r_cfill}) : 14'h0;
            o_job.file_end     = 1'b1;
            o_job.file_crc     = r_file_crc ^ CRC_INIT;
            o_job.file_length  = r_total;
            o_job.chunk_count  = r_chunks + {6'h0, close_end};
            o_job.too_long     = r_over;
            n_group            = '0;
            n_gfill            = '0;
            n_cfill            = '0;
            n_chunk_crc        = CRC_INIT;
            n_file_crc         = CRC_INIT;
            n_total            = '0;
            n_chunks           = '0;
            n_over             = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group     <= '0;
            r_gfill     <= '0;
            r_cfill     <= '0;
            r_chunk_crc <= CRC_INIT;
            r_file_crc  <= CRC_INIT;
            r_total     <= '0;
            r_chunks    <= '0;
            r_over      <= 1'b0;
        end else if (i_accept) begin
            r_group     <= n_group;
            r_gfill     <= n_gfill;
            r_cfill     <= n_cfill;
            r_chunk_crc <= n_chunk_crc;
            r_file_crc  <= n_file_crc;
            r_total     <= n_total;
            r_chunks    <= n_chunks;
            r_over      <= n_over;
        end
    end

endmodule

### rtl/core/cbe_fifo.sv
// Short job queue between the front end and the character back end.
module cbe_fifo
    import cbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr;
    logic [JOB_PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (JOB_PTR_W+1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + JOB_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + JOB_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (JOB_PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (JOB_PTR_W+1)'(1);
            end
        end
    end

endmodule

### rtl/core/cbe_back.sv
// Back end: expands each job into result beats and holds them in the output register.
module cbe_back
    import cbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_empty,
    input  t_job i_job,
    output logic o_job_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    logic [1:0] r_row;
    logic       r_valid;
    t_res       r_res;
    t_res       n_res;
    logic       last_row;
    logic       advance;
    logic [5:0] sextet;

    always_comb begin
        last_row = !i_job.has_chars || (r_row == 2'd3);
        advance  = !i_job_empty && (!r_valid || i_pop);

        case (r_row)
            2'd0:    sextet = i_job.group[23:18];
            2'd1:    sextet = i_job.group[17:12];
            2'd2:    sextet = i_job.group[11:6];
            default: sextet = i_job.group[5:0];
        endcase

        n_res = '0;
        if (i_job.has_chars) begin
            n_res.char_valid = 1'b1;
            if ((r_row == 2'd2 && i_job.fill < 2'd2) || (r_row == 2'd3 && i_job.fill < 2'd3)) begin
                n_res.b64_char = PAD_CHAR;
            end else begin
                n_res.b64_char = b64_symbol(sextet);
            end
        end
        if (last_row) begin
            n_res.chunk_end    = i_job.chunk_end;
            n_res.chunk_crc    = i_job.chunk_crc;
            n_res.chunk_offset = i_job.chunk_offset;
            n_res.file_end     = i_job.file_end;
            n_res.file_crc     = i_job.file_crc;
            n_res.file_length  = i_job.file_length;
            n_res.chunk_count  = i_job.chunk_count;
            n_res.too_long     = i_job.too_long;
        end
    end

    assign o_job_pop = advance && last_row;
    assign o_empty   = !r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_row   <= last_row ? 2'd0 : r_row + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### tb/tb.sv
// Self-checking testbench of the chunked Base64 encoder with chunk and file CRC-32C.
`timescale 1ns / 100ps

module tb;
    import cbe_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 460;
    localparam int IDLE_PERCENT  = 36;
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic typed;
        t_in  beat;
        t_res want;
    } t_dir_row;

    localparam t_res EMPTY_FILE_END = '{file_end: 1'b1, default: '0};
    localparam int DIRECTED_ROWS = 18;
    localparam t_dir_row DIRECTED[DIRECTED_ROWS] = '{
        '{1'b1, '{REQ_END,  8'h00}, EMPTY_FILE_END},
        '{1'b1, '{REQ_END,  8'hff}, EMPTY_FILE_END},
        '{1'b0, '{REQ_DATA, 8'h00}, '0},
        '{1'b0, '{REQ_END,  8'h00}, '0},
        '{1'b0, '{REQ_DATA, 8'hff}, '0},
        '{1'b0, '{REQ_DATA, 8'hff}, '0},
        '{1'b0, '{REQ_END,  8'hff}, '0},
        '{1'b0, '{REQ_DATA, 8'h4d}, '0},
        '{1'b0, '{REQ_DATA, 8'h61}, '0},
        '{1'b0, '{REQ_DATA, 8'h6e}, '0},
        '{1'b0, '{REQ_END,  8'h00}, '0},
        '{1'b0, '{REQ_DATA, 8'hff}, '0},
        '{1'b0, '{REQ_DATA, 8'h00}, '0},
        '{1'b0, '{REQ_DATA, 8'hff}, '0},
        '{1'b0, '{REQ_DATA, 8'ha5}, '0},
        '{1'b0, '{REQ_END,  8'h5a}, '0},
        '{1'b0, '{REQ_DATA, 8'h5a}, '0},
        '{1'b0, '{REQ_END,  8'ha5}, '0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_item  = '0;
    logic full;
    logic empty;
    t_res o_result;

    logic        gaps_on = 1'b1;
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    int          items_sent = 0;

    logic [23:0] held_bytes;
    logic [1:0]  held_count;
    logic [7:0]  chunk_len;
    logic [31:0] chunk_crc_run;
    logic [31:0] file_crc_run;
    logic [13:0] file_len;
    logic [6:0]  chunks_closed;
    logic        bytes_dropped;
    t_res        fresh_beats[$];
    t_res        expected_beats[$];

    chunked_base64_crc32c_encoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] crc32c_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] acc;
        acc = crc;
        for (int k = 0; k < 8; k++) begin
            acc = (acc[0] ^ b[k]) ? ({1'b0, acc[31:1]} ^ CRC_POLY) : {1'b0, acc[31:1]};
        end
        return acc;
    endfunction

    function automatic logic [6:0] b64_letter(input logic [5:0] idx);
        return B64_ALPHABET[8 * (63 - int'(idx)) +: 7];
    endfunction

    task automatic clear_file_state();
        held_bytes    = '0;
        held_count    = '0;
        chunk_len     = '0;
        chunk_crc_run = CRC_INIT;
        file_crc_run  = CRC_INIT;
        file_len      = '0;
        chunks_closed = '0;
        bytes_dropped = 1'b0;
    endtask

    // The pending bytes become four characters, padded with '=' past the held count.
    task automatic emit_held();
        logic [23:0] v;
        t_res        beat;
        case (held_count)
            2'd3: begin
                v = held_bytes;
            end
            2'd2: begin
                v = {held_bytes[15:0], 8'h00};
            end
            default: begin
                v = {held_bytes[7:0], 16'h0000};
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            beat = '0;
            beat.char_valid = 1'b1;
            beat.b64_char = (k > held_count) ? PAD_CHAR : b64_letter(v[23 - 6 * k -: 6]);
            fresh_beats.push_back(beat);
        end
        held_bytes = '0;
        held_count = '0;
    endtask

    task automatic close_chunk_beat();
        t_res beat;
        beat = fresh_beats.pop_back();
        beat.chunk_end    = 1'b1;
        beat.chunk_crc    = ~chunk_crc_run;
        beat.chunk_offset = file_len - 14'(chunk_len);
        fresh_beats.push_back(beat);
        chunks_closed = chunks_closed + 7'd1;
        chunk_len     = '0;
        chunk_crc_run = CRC_INIT;
    endtask

    task automatic predict_encoding(input t_in beat);
        t_res last;
        fresh_beats.delete();
        if (beat.req_type == REQ_DATA) begin
            if (chunks_closed >= MAX_CHUNK_COUNT) begin
                bytes_dropped = 1'b1;
                return;
            end
            chunk_crc_run = crc32c_update(chunk_crc_run, beat.data_byte);
            file_crc_run  = crc32c_update(file_crc_run, beat.data_byte);
            held_bytes    = {held_bytes[15:0], beat.data_byte};
            held_count    = held_count + 2'd1;
            file_len      = file_len + 14'd1;
            chunk_len     = chunk_len + 8'd1;
            if (held_count == 2'd3 || chunk_len >= CHUNK_BYTES) begin
                emit_held();
            end
            if (chunk_len >= CHUNK_BYTES) begin
                close_chunk_beat();
            end
        end else begin
            if (held_count != 2'd0) begin
                emit_held();
            end
            if (fresh_beats.size() == 0) begin
                fresh_beats.push_back('0);
            end
            if (chunk_len != 8'd0) begin
                close_chunk_beat();
            end
            last = fresh_beats.pop_back();
            last.file_end    = 1'b1;
            last.file_crc    = ~file_crc_run;
            last.file_length = file_len;
            last.chunk_count = chunks_closed;
            last.too_long    = bytes_dropped;
            fresh_beats.push_back(last);
            clear_file_state();
        end
        foreach (fresh_beats[k]) begin
            expected_beats.push_back(fresh_beats[k]);
        end
    endtask

    // Push stays high from one beat to the next unless an idle cycle is drawn.
    task automatic push_beat(input t_in beat);
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_encoding(beat);
    endtask

    task automatic send_file(input int file_bytes);
        for (int n = 0; n < file_bytes; n++) begin
            gaps_on = !(items_sent >= 150 && items_sent < 300);
            push_beat(t_in'{REQ_DATA, 8'($urandom_range(255))});
            items_sent++;
        end
        push_beat(t_in'{REQ_END, 8'($urandom_range(255))});
        items_sent++;
    endtask

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatch_count++;
    endfunction

    task automatic check_beat(input t_res got, input t_res want);
        if (got.char_valid !== want.char_valid) begin
            report_field("char_valid", 32'(want.char_valid), 32'(got.char_valid));
        end
        if (got.b64_char !== want.b64_char) begin
            report_field("b64_char", 32'(want.b64_char), 32'(got.b64_char));
        end
        if (got.chunk_end !== want.chunk_end) begin
            report_field("chunk_end", 32'(want.chunk_end), 32'(got.chunk_end));
        end
        if (got.chunk_crc !== want.chunk_crc) begin
            report_field("chunk_crc", want.chunk_crc, got.chunk_crc);
        end
        if (got.chunk_offset !== want.chunk_offset) begin
            report_field("chunk_offset", 32'(want.chunk_offset), 32'(got.chunk_offset));
        end
        if (got.file_end !== want.file_end) begin
            report_field("file_end", 32'(want.file_end), 32'(got.file_end));
        end
        if (got.file_crc !== want.file_crc) begin
            report_field("file_crc", want.file_crc, got.file_crc);
        end
        if (got.file_length !== want.file_length) begin
            report_field("file_length", 32'(want.file_length), 32'(got.file_length));
        end
        if (got.chunk_count !== want.chunk_count) begin
            report_field("chunk_count", 32'(want.chunk_count), 32'(got.chunk_count));
        end
        if (got.too_long !== want.too_long) begin
            report_field("too_long", 32'(want.too_long), 32'(got.too_long));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with no expectation waiting");
                mismatch_count++;
            end else begin
                check_beat(o_result, expected_beats.pop_front());
            end
        end
        pop <= i_rst_n && (!gaps_on || $urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int pick;
        int file_bytes;
        clear_file_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            push_beat(DIRECTED[r].beat);
            if (DIRECTED[r].typed) begin
                expected_beats[expected_beats.size() - 1] = DIRECTED[r].want;
            end
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                file_bytes = int'($urandom_range(10));
            end else if (pick < 88) begin
                file_bytes = int'($urandom_range(60, 11));
            end else if (pick < 95) begin
                file_bytes = int'($urandom_range(400, 170));
            end else begin
                file_bytes = int'(CHUNK_BYTES) * int'($urandom_range(2, 1));
            end
            if (file_bytes > RANDOM_ITEMS - items_sent) begin
                file_bytes = RANDOM_ITEMS - items_sent;
            end
            send_file(file_bytes);
        end

        send_file(int'($urandom_range(8, 1)));

        push <= 1'b0;
        while (expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
